### sv/ntlm_des_response_block_macros.svh
// assertion macros for the ntlm des response block
// no dependencies; included by modules that carry assertions
`ifndef NTLM_DES_RESPONSE_BLOCK_MACROS_SVH
`define NTLM_DES_RESPONSE_BLOCK_MACROS_SVH
`ifndef SYNTHESIS
`define NDR_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define NDR_ASSERT_NR(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NDR_ASSERT(label, clk, rst_n, prop, msg)
`define NDR_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

### sv/ndr_pkg.sv
// package for the ntlm des response block: types, constants, des tables
// no dependencies
package ndr_pkg;

	localparam int KeyW = 56;
	localparam int BlkW = 64;
	localparam int RoundCnt = 16;
	localparam int FifoDepthDef = 4;
	localparam logic [63:0] LmMagic = 64'h4B47532140232425;

	typedef enum logic {
		KIND_RESPONSE = 1'b0,
		KIND_LM       = 1'b1
	} kind_t;

	// classified work item handed from front to back
	typedef struct packed {
		logic [55:0] cd;
		logic [63:0] lr;
	} job_t;

	// round pipeline stage payload
	typedef struct packed {
		logic [27:0] c;
		logic [27:0] d;
		logic [31:0] l;
		logic [31:0] r;
	} rnd_t;

	typedef logic [7:0] tab64_t [64];

	localparam tab64_t IpTab = '{
		8'd58,8'd50,8'd42,8'd34,8'd26,8'd18,8'd10,8'd2,8'd60,8'd52,8'd44,8'd36,8'd28,8'd20,
		8'd12,8'd4,8'd62,8'd54,8'd46,8'd38,8'd30,8'd22,8'd14,8'd6,8'd64,8'd56,8'd48,8'd40,
		8'd32,8'd24,8'd16,8'd8,8'd57,8'd49,8'd41,8'd33,8'd25,8'd17,8'd9,8'd1,8'd59,8'd51,
		8'd43,8'd35,8'd27,8'd19,8'd11,8'd3,8'd61,8'd53,8'd45,8'd37,8'd29,8'd21,8'd13,8'd5,
		8'd63,8'd55,8'd47,8'd39,8'd31,8'd23,8'd15,8'd7};

	localparam tab64_t FpTab = '{
		8'd40,8'd8,8'd48,8'd16,8'd56,8'd24,8'd64,8'd32,8'd39,8'd7,8'd47,8'd15,8'd55,8'd23,
		8'd63,8'd31,8'd38,8'd6,8'd46,8'd14,8'd54,8'd22,8'd62,8'd30,8'd37,8'd5,8'd45,8'd13,
		8'd53,8'd21,8'd61,8'd29,8'd36,8'd4,8'd44,8'd12,8'd52,8'd20,8'd60,8'd28,8'd35,8'd3,
		8'd43,8'd11,8'd51,8'd19,8'd59,8'd27,8'd34,8'd2,8'd42,8'd10,8'd50,8'd18,8'd58,8'd26,
		8'd33,8'd1,8'd41,8'd9,8'd49,8'd17,8'd57,8'd25};

	localparam logic [7:0] ETab [48] = '{
		8'd32,8'd1,8'd2,8'd3,8'd4,8'd5,8'd4,8'd5,8'd6,8'd7,8'd8,8'd9,8'd8,8'd9,8'd10,8'd11,
		8'd12,8'd13,8'd12,8'd13,8'd14,8'd15,8'd16,8'd17,8'd16,8'd17,8'd18,8'd19,8'd20,8'd21,
		8'd20,8'd21,8'd22,8'd23,8'd24,8'd25,8'd24,8'd25,8'd26,8'd27,8'd28,8'd29,8'd28,8'd29,
		8'd30,8'd31,8'd32,8'd1};

	localparam logic [7:0] PTab [32] = '{
		8'd16,8'd7,8'd20,8'd21,8'd29,8'd12,8'd28,8'd17,8'd1,8'd15,8'd23,8'd26,8'd5,8'd18,
		8'd31,8'd10,8'd2,8'd8,8'd24,8'd14,8'd32,8'd27,8'd3,8'd9,8'd19,8'd13,8'd30,8'd6,
		8'd22,8'd11,8'd4,8'd25};

	localparam logic [7:0] Pc1Tab [56] = '{
		8'd57,8'd49,8'd41,8'd33,8'd25,8'd17,8'd9,8'd1,8'd58,8'd50,8'd42,8'd34,8'd26,8'd18,
		8'd10,8'd2,8'd59,8'd51,8'd43,8'd35,8'd27,8'd19,8'd11,8'd3,8'd60,8'd52,8'd44,8'd36,
		8'd63,8'd55,8'd47,8'd39,8'd31,8'd23,8'd15,8'd7,8'd62,8'd54,8'd46,8'd38,8'd30,8'd22,
		8'd14,8'd6,8'd61,8'd53,8'd45,8'd37,8'd29,8'd21,8'd13,8'd5,8'd28,8'd20,8'd12,8'd4};

	localparam logic [7:0] Pc2Tab [48] = '{
		8'd14,8'd17,8'd11,8'd24,8'd1,8'd5,8'd3,8'd28,8'd15,8'd6,8'd21,8'd10,8'd23,8'd19,
		8'd12,8'd4,8'd26,8'd8,8'd16,8'd7,8'd27,8'd20,8'd13,8'd2,8'd41,8'd52,8'd31,8'd37,
		8'd47,8'd55,8'd30,8'd40,8'd51,8'd45,8'd33,8'd48,8'd44,8'd49,8'd39,8'd56,8'd34,8'd53,
		8'd46,8'd42,8'd50,8'd36,8'd29,8'd32};

	localparam logic [15:0] RotTwo = 16'b0111111011111100; // bit i: round i shifts by two

	localparam logic [3:0] SBox [8][64] = '{
		'{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
		  4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
		  4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
		  4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
		'{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
		  4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
		  4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
		  4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
		'{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
		  4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
		  4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
		  4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
		'{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
		  4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
		  4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
		  4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
		'{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
		  4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
		  4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
		  4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
		'{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
		  4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
		  4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
		  4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
		'{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
		  4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
		  4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
		  4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
		'{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
		  4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
		  4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
		  4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd5,4'd6,4'd11,4'd3}};

	function automatic logic [63:0] perm64(input logic [63:0] v, input tab64_t tab);
		logic [63:0] r;
		r = '0;
		for (int i = 0; i < 64; i++) r[63-i] = v[64 - int'(tab[i])];
		return r;
	endfunction

	function automatic logic [55:0] pc1(input logic [63:0] v);
		logic [55:0] r;
		r = '0;
		for (int i = 0; i < 56; i++) r[55-i] = v[64 - int'(Pc1Tab[i])];
		return r;
	endfunction

	function automatic logic [47:0] pc2(input logic [55:0] v);
		logic [47:0] r;
		r = '0;
		for (int i = 0; i < 48; i++) r[47-i] = v[56 - int'(Pc2Tab[i])];
		return r;
	endfunction

	function automatic logic [31:0] feistel(input logic [31:0] rv, input logic [47:0] sub);
		logic [47:0] x;
		logic [31:0] s;
		logic [31:0] p;
		logic [5:0] six;
		x = '0;
		s = '0;
		p = '0;
		six = '0;
		for (int i = 0; i < 48; i++) x[47-i] = rv[32 - int'(ETab[i])];
		x = x ^ sub;
		for (int i = 0; i < 8; i++) begin
			six = x[42-6*i +: 6];
			s[28-4*i +: 4] = SBox[i][{six[5], six[0], six[4:1]}];
		end
		for (int i = 0; i < 32; i++) p[31-i] = s[32 - int'(PTab[i])];
		return p;
	endfunction

endpackage

### sv/ntlm_des_response_block.sv
// ntlm v1 des response block top level
// depends on ndr_pkg, ndr_front, ndr_fifo, ndr_back
//
// usage: one transaction on s_axis carries kind, a 56-bit key slice and a
// 64-bit block; one transaction on m_axis returns the 64-bit des ciphertext.
// kind 0 encrypts the given block; kind 1 uppercases the key (a-z only) and
// encrypts the lm constant. three kind 0 transactions with the three slices
// of a 21-byte hash give the 24-byte response.
// path: the front register loads at the accepting edge, then the job is written
// to the queue and passes the sixteen round stages and one output register.
// throughput: one transaction per cycle while a waiting result does not stall it,
// set by the fully unrolled sixteen-stage round pipeline.
// a result waiting on m_axis_tready holds round pipeline and output register;
// the front keeps accepting until the queue fills, then s_axis_tready drops.
// reset clears all valid flags and queue pointers; no clearing pass.
module ntlm_des_response_block
	import ndr_pkg::*;
#(
	parameter int FifoDepth = FifoDepthDef
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [119:0] s_axis_tdata,  // key_bytes[55:0], data_block[119:56]
	input  logic         s_axis_tuser,  // kind
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [63:0]  m_axis_tdata   // cipher_block[63:0]
);

	logic fr_valid;
	logic fr_ready;
	job_t fr_job;
	logic bk_valid;
	logic bk_ready;
	job_t bk_job;

	ndr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.kind       (s_axis_tuser),
		.key_bytes  (s_axis_tdata[55:0]),
		.data_block (s_axis_tdata[119:56]),
		.job_valid  (fr_valid),
		.job_ready  (fr_ready),
		.job        (fr_job)
	);

	ndr_fifo #(.Depth(FifoDepth)) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fr_valid),
		.wr_ready (fr_ready),
		.wr_data  (fr_job),
		.rd_valid (bk_valid),
		.rd_ready (bk_ready),
		.rd_data  (bk_job)
	);

	ndr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (bk_valid),
		.job_ready (bk_ready),
		.job       (bk_job),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cipher    (m_axis_tdata)
	);

endmodule

### sv/ndr_front.sv
// front end: accepts transactions, uppercases lm keys, spreads parity, applies pc1 and ip
// depends on ndr_pkg
module ndr_front
	import ndr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [55:0] key_bytes,
	input  logic [63:0] data_block,
	output logic        job_valid,
	input  logic        job_ready,
	output job_t        job
);

	logic        valid_q;
	job_t        job_q;
	logic [55:0] k56;
	logic [63:0] key64;
	logic [63:0] blk;
	logic [7:0]  ch;

	always_comb begin
		k56 = key_bytes;
		key64 = '0;
		ch = '0;
		if (kind_t'(kind) == KIND_LM) begin
			for (int b = 0; b < 7; b++) begin
				ch = key_bytes[8*b +: 8];
				if (ch >= 8'h61 && ch <= 8'h7A) ch = ch - 8'h20;
				k56[8*b +: 8] = ch;
			end
		end
		// odd parity lands in each byte's low bit
		for (int b = 0; b < 8; b++)
			key64[8*b +: 8] = {k56[7*b +: 7], ~^k56[7*b +: 7]};
		blk = (kind_t'(kind) == KIND_LM) ? LmMagic : data_block;
	end

	assign in_ready  = !valid_q || job_ready;
	assign job_valid = valid_q;
	assign job       = job_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			job_q <= '{cd: pc1(key64), lr: perm64(blk, IpTab)};
		end
	end

endmodule

### sv/ndr_fifo.sv
// short queue between front and back ends
// depends on ndr_pkg and the assertion macros
`include "ntlm_des_response_block_macros.svh"
module ndr_fifo
	import ndr_pkg::*;
#(
	parameter int Depth = FifoDepthDef
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  job_t wr_data,
	output logic rd_valid,
	input  logic rd_ready,
	output job_t rd_data
);

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

	job_t                mem [Depth];
	logic [AW-1:0]       wp_q;
	logic [AW-1:0]       rp_q;
	logic [$clog2(Depth+1)-1:0] cnt_q;
	logic                push;
	logic                pop;

	assign wr_ready = cnt_q != Depth[$clog2(Depth+1)-1:0];
	assign rd_valid = cnt_q != '0;
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_data  = mem[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
			if (pop)  rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem[wp_q] <= wr_data;
	end

	`NDR_ASSERT(a_no_overflow, clk, arst_n, cnt_q == Depth[$clog2(Depth+1)-1:0] |-> !push,
		"queue overflow")
	`NDR_ASSERT(a_no_underflow, clk, arst_n, cnt_q == '0 |-> !pop, "queue underflow")
	`NDR_ASSERT(a_count_step, clk, arst_n, (push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1,
		"queue count did not advance")

endmodule

### sv/ndr_back.sv
// back end: sixteen-round des pipeline with fp and an output register
// depends on ndr_pkg and the assertion macros
`include "ntlm_des_response_block_macros.svh"
module ndr_back
	import ndr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        job_valid,
	output logic        job_ready,
	input  job_t        job,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] cipher
);

	logic [RoundCnt-1:0] vld_s1;
	rnd_t                rnd_s1 [RoundCnt];
	logic [63:0]         out_q;
	logic                out_vld_q;
	logic                adv;
	rnd_t                nxt [RoundCnt];
	rnd_t                src [RoundCnt];

	// whole pipe moves together; it stalls only when the output register is held
	assign adv       = !out_vld_q || out_ready;
	assign job_ready = adv;
	assign out_valid = out_vld_q;
	assign cipher    = out_q;

	always_comb begin
		for (int i = 0; i < RoundCnt; i++) begin
			if (i == 0) src[i] = '{c: job.cd[55:28], d: job.cd[27:0],
				l: job.lr[63:32], r: job.lr[31:0]};
			else src[i] = rnd_s1[i-1];
			if (RotTwo[i]) begin
				nxt[i].c = {src[i].c[25:0], src[i].c[27:26]};
				nxt[i].d = {src[i].d[25:0], src[i].d[27:26]};
			end else begin
				nxt[i].c = {src[i].c[26:0], src[i].c[27]};
				nxt[i].d = {src[i].d[26:0], src[i].d[27]};
			end
			nxt[i].l = src[i].r;
			nxt[i].r = src[i].l ^ feistel(src[i].r, pc2({nxt[i].c, nxt[i].d}));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= '0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s1    <= {vld_s1[RoundCnt-2:0], job_valid};
			out_vld_q <= vld_s1[RoundCnt-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < RoundCnt; i++) rnd_s1[i] <= nxt[i];
			out_q <= perm64({rnd_s1[RoundCnt-1].r, rnd_s1[RoundCnt-1].l}, FpTab);
		end
	end

	`NDR_ASSERT(a_out_hold, clk, arst_n, (out_vld_q && !out_ready) |=> out_vld_q,
		"result dropped while stalled")
	`NDR_ASSERT(a_pipe_load, clk, arst_n, (adv && vld_s1[RoundCnt-1]) |=> out_vld_q,
		"last round did not reach output")
	`NDR_ASSERT(a_stall_freeze, clk, arst_n, !adv |=> $stable(vld_s1),
		"pipeline moved during stall")

endmodule
